>>> design/bmpd_pkg.sv
package bmpd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_PAD,
        PH_TAIL,
        PH_IGNORE
    } phase_t;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_SHORT_HEADER = 4'd1,
        ST_TYPE         = 4'd2,
        ST_SIZE         = 4'd3,
        ST_RESERVED     = 4'd4,
        ST_WIDTH        = 4'd5,
        ST_HEIGHT       = 4'd6,
        ST_PLANES       = 4'd7,
        ST_BITCOUNT     = 4'd8,
        ST_COMPRESSION  = 4'd9,
        ST_SHORT_IMAGE  = 4'd10
    } status_t;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Byte positions within the header at which a field completes
    localparam logic [5:0] POS_TYPE        = 6'd1;
    localparam logic [5:0] POS_SIZE        = 6'd5;
    localparam logic [5:0] POS_RESERVED    = 6'd9;
    localparam logic [5:0] POS_OFFSET      = 6'd13;
    localparam logic [5:0] POS_WIDTH       = 6'd21;
    localparam logic [5:0] POS_HEIGHT      = 6'd25;
    localparam logic [5:0] POS_PRODUCT     = 6'd26;
    localparam logic [5:0] POS_PLANES      = 6'd27;
    localparam logic [5:0] POS_REQUIRED    = 6'd27;
    localparam logic [5:0] POS_BITCOUNT    = 6'd29;
    localparam logic [5:0] POS_COMPRESSION = 6'd33;
    localparam logic [5:0] POS_HEADER_END  = 6'd53;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4d42;
    localparam logic [15:0] BMP_PLANES    = 16'd1;
    localparam logic [15:0] BMP_BITCOUNT  = 16'd24;
    localparam logic [31:0] POS_MAX       = 32'hFFFF_FFFF;

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [11:0] column;
        logic [11:0] row;
        status_t     status;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t status_result(input status_t st);
        result_t r;
        r        = '0;
        r.kind   = KIND_STATUS;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

endpackage

>>> design/bmp24_stream_decoder.sv
// Latency: a result item is offered the cycle after its byte is accepted, queue empty.
// Throughput: one file byte per cycle; header checks and pixel counters update in that
// cycle. A byte can yield a pixel and a status; a four-entry result queue takes both,
// and in_ready drops only while three or more result items wait.
// Reset: rst_n is asynchronous, active low; it returns the decoder to the header and
// empties the result queue.
module bmp24_stream_decoder
    import bmpd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  blue,
    output logic [7:0]  green,
    output logic [7:0]  red,
    output logic [11:0] column,
    output logic [11:0] row,
    output logic [3:0]  status,
    output logic        last
);

    push_t   push;
    result_t head;
    logic    room;
    logic    step;

    assign in_ready = room;
    assign step     = in_valid && in_ready;

    bmpd_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .push        (push)
    );

    bmpd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind   = head.kind;
    assign blue   = head.blue;
    assign green  = head.green;
    assign red    = head.red;
    assign column = head.column;
    assign row    = head.row;
    assign status = head.status;
    assign last   = head.last;

endmodule

>>> design/bmpd_core.sv
module bmpd_core
    import bmpd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       end_of_file,
    output push_t      push
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int BW = WW + 2;
    localparam int PW = BW + HW;
    localparam int RW = ((PW > 32) ? PW : 32) + 1;

    phase_t          phase_reg, phase_next;
    logic [31:0]     pos_reg, pos_next;
    logic [31:0]     shift_reg, shift_next;
    logic [31:0]     size_reg, size_next;
    logic [31:0]     offset_reg, offset_next;
    logic [WW-1:0]   width_reg, width_next;
    logic [HW-1:0]   height_reg, height_next;
    logic [15:0]     hold_reg, hold_next;
    logic [1:0]      chan_reg, chan_next;
    logic [WW-1:0]   col_reg, col_next;
    logic [HW-1:0]   row_reg, row_next;
    logic [1:0]      pad_reg, pad_next;

    logic [PW-1:0]   prod_reg;
    logic [RW-1:0]   required_reg;

    logic [BW-1:0]   width_ext;
    logic [BW-1:0]   row_bytes;
    logic [31:0]     pos_inc;
    logic [RW-1:0]   arrived;
    logic [WW:0]     col_inc;
    logic [HW:0]     row_inc;
    logic            clear;
    logic            err_hit;
    status_t         err;
    logic            done;
    logic            pixel_out;
    result_t         pixel;
    result_t         stat;

    assign width_ext = BW'(width_reg);
    assign row_bytes = (width_ext << 1) + width_ext + (width_ext & BW'(3));
    assign pos_inc   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 32'd1;
    assign arrived   = RW'(pos_reg) + RW'(1);

    // Byte count the image needs, built while the header runs out
    always_ff @(posedge clk)
    begin
        if (step && phase_reg == PH_HEADER && pos_reg[5:0] == POS_PRODUCT)
        begin
            prod_reg <= PW'(row_bytes) * PW'(height_reg);
        end
        if (step && phase_reg == PH_HEADER && pos_reg[5:0] == POS_REQUIRED)
        begin
            required_reg <= RW'(offset_reg) + RW'(prod_reg);
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        shift_next  = shift_reg;
        size_next   = size_reg;
        offset_next = offset_reg;
        width_next  = width_reg;
        height_next = height_reg;
        hold_next   = hold_reg;
        chan_next   = chan_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pad_next    = pad_reg;
        push        = '0;
        clear       = 1'b0;
        err_hit     = 1'b0;
        err         = ST_OK;
        done        = 1'b0;
        pixel_out   = 1'b0;
        col_inc     = {1'b0, col_reg} + (WW+1)'(1);
        row_inc     = {1'b0, row_reg} + (HW+1)'(1);
        stat        = status_result(ST_OK);

        pixel        = '0;
        pixel.kind   = KIND_PIXEL;
        pixel.blue   = hold_reg[7:0];
        pixel.green  = hold_reg[15:8];
        pixel.red    = data_byte;
        pixel.column = 12'(col_reg);
        pixel.row    = 12'(row_reg);
        pixel.status = ST_OK;
        pixel.last   = 1'b0;

        if (step)
        begin
            case (phase_reg)
                PH_IGNORE:
                begin
                    if (end_of_file)
                    begin
                        clear = 1'b1;
                    end
                end
                PH_HEADER:
                begin
                    shift_next = {data_byte, shift_reg[31:8]};
                    case (pos_reg[5:0])
                        POS_TYPE:
                        begin
                            if (shift_next[31:16] != BMP_SIGNATURE)
                            begin
                                err_hit = 1'b1;
                                err     = ST_TYPE;
                            end
                        end
                        POS_SIZE:
                        begin
                            size_next = shift_next;
                            if (shift_next == 32'd0)
                            begin
                                err_hit = 1'b1;
                                err     = ST_SIZE;
                            end
                        end
                        POS_RESERVED:
                        begin
                            if (shift_next != 32'd0)
                            begin
                                err_hit = 1'b1;
                                err     = ST_RESERVED;
                            end
                        end
                        POS_OFFSET:
                        begin
                            offset_next = shift_next;
                        end
                        POS_WIDTH:
                        begin
                            if (shift_next == 32'd0 || shift_next > 32'(MAX_WIDTH))
                            begin
                                err_hit = 1'b1;
                                err     = ST_WIDTH;
                            end
                            else
                            begin
                                width_next = shift_next[WW-1:0];
                            end
                        end
                        POS_HEIGHT:
                        begin
                            if (shift_next == 32'd0 || shift_next > 32'(MAX_HEIGHT))
                            begin
                                err_hit = 1'b1;
                                err     = ST_HEIGHT;
                            end
                            else
                            begin
                                height_next = shift_next[HW-1:0];
                            end
                        end
                        POS_PLANES:
                        begin
                            if (shift_next[31:16] != BMP_PLANES)
                            begin
                                err_hit = 1'b1;
                                err     = ST_PLANES;
                            end
                        end
                        POS_BITCOUNT:
                        begin
                            if (shift_next[31:16] != BMP_BITCOUNT)
                            begin
                                err_hit = 1'b1;
                                err     = ST_BITCOUNT;
                            end
                        end
                        POS_COMPRESSION:
                        begin
                            if (shift_next != 32'd0)
                            begin
                                err_hit = 1'b1;
                                err     = ST_COMPRESSION;
                            end
                        end
                        POS_HEADER_END:
                        begin
                            phase_next = PH_PIXEL;
                        end
                        default:
                        begin
                        end
                    endcase
                    pos_next = pos_inc;
                    if (err_hit)
                    begin
                        push.count = 2'd1;
                        push.first = status_result(err);
                        if (end_of_file)
                        begin
                            clear = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_IGNORE;
                        end
                    end
                    else if (end_of_file)
                    begin
                        push.count = 2'd1;
                        push.first = status_result((phase_next == PH_PIXEL) ?
                                                   ST_SHORT_IMAGE : ST_SHORT_HEADER);
                        clear      = 1'b1;
                    end
                end
                default:
                begin
                    if (phase_reg == PH_PIXEL)
                    begin
                        if (chan_reg < 2'd2)
                        begin
                            // Gather blue then green
                            if (chan_reg == 2'd0)
                            begin
                                hold_next[7:0] = data_byte;
                            end
                            else
                            begin
                                hold_next[15:8] = data_byte;
                            end
                            chan_next = chan_reg + 2'd1;
                        end
                        else
                        begin
                            pixel_out = 1'b1;
                            hold_next = 16'd0;
                            chan_next = 2'd0;
                            col_next  = col_inc[WW-1:0];
                            if (col_inc >= {1'b0, width_reg})
                            begin
                                col_next = '0;
                                row_next = row_inc[HW-1:0];
                                if (row_inc >= {1'b0, height_reg})
                                begin
                                    phase_next = PH_TAIL;
                                end
                                else if (width_ext[1:0] != 2'd0)
                                begin
                                    pad_next   = width_ext[1:0];
                                    phase_next = PH_PAD;
                                end
                            end
                        end
                    end
                    else if (phase_reg == PH_PAD)
                    begin
                        pad_next = pad_reg - 2'd1;
                        if (pad_next == 2'd0)
                        begin
                            phase_next = PH_PIXEL;
                        end
                    end

                    done     = (phase_next == PH_TAIL) && (arrived >= required_reg);
                    pos_next = pos_inc;

                    if (done)
                    begin
                        stat = status_result(ST_OK);
                        if (end_of_file)
                        begin
                            clear = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_IGNORE;
                        end
                    end
                    else if (end_of_file)
                    begin
                        stat  = status_result(ST_SHORT_IMAGE);
                        clear = 1'b1;
                    end

                    // Pixel goes first, status behind it
                    if (pixel_out)
                    begin
                        push.first = pixel;
                        push.second = stat;
                        push.count = (done || end_of_file) ? 2'd2 : 2'd1;
                    end
                    else if (done || end_of_file)
                    begin
                        push.first = stat;
                        push.count = 2'd1;
                    end
                end
            endcase

            if (clear)
            begin
                phase_next  = PH_HEADER;
                pos_next    = 32'd0;
                shift_next  = 32'd0;
                size_next   = 32'd0;
                offset_next = 32'd0;
                width_next  = '0;
                height_next = '0;
                hold_next   = 16'd0;
                chan_next   = 2'd0;
                col_next    = '0;
                row_next    = '0;
                pad_next    = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= 32'd0;
            shift_reg  <= 32'd0;
            size_reg   <= 32'd0;
            offset_reg <= 32'd0;
            width_reg  <= '0;
            height_reg <= '0;
            hold_reg   <= 16'd0;
            chan_reg   <= 2'd0;
            col_reg    <= '0;
            row_reg    <= '0;
            pad_reg    <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            size_reg   <= size_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            hold_reg   <= hold_next;
            chan_reg   <= chan_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pad_reg    <= pad_next;
        end
    end

endmodule

>>> design/bmpd_result_fifo.sv
module bmpd_result_fifo
    import bmpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t head
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    result_t       mem_reg [FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] wr_ptr_second;
    logic          pop;

    // Leave space for the two items one input byte can produce
    assign room          = count_reg <= CW'(FIFO_DEPTH - 2);
    assign out_valid     = count_reg != '0;
    assign head          = mem_reg[rd_ptr_reg];
    assign pop           = out_valid && out_ready;
    assign wr_ptr_second = wr_ptr_reg + AW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push.count);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
